// ===== rtl/core/adsp_pkg.sv =====
// widths, register indexes, operation codes and controller states for the
// accel/decel step pacer; no dependencies
`default_nettype none

package adsp_pkg;

   localparam int POS_W      = 24;
   localparam int PER_W      = 16;
   localparam int STEP_W     = 16;
   localparam int PCT_W      = 7;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 3;

   // shared restoring divider
   localparam int DVD_W = POS_W + PER_W;
   localparam int DVS_W = POS_W + 1;
   localparam int QUO_W = POS_W + 1;
   localparam int CNT_W = $clog2(DVD_W);

   localparam int PCT_SCALE = 100;

   localparam logic [PER_W:0]   PER_CAP  = {1'b1, {PER_W{1'b0}}};
   localparam logic [PER_W-1:0] PER_ONES = {PER_W{1'b1}};

   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_START = 2'd1;
   localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PERIOD   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PERIOD   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_POSITION = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CYCLE_MODE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_PCT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_PCT     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_NOTIFY       = 3'd7;

   localparam logic [PER_W-1:0]  RST_MIN_PERIOD = 16'd10;
   localparam logic [PER_W-1:0]  RST_MAX_PERIOD = 16'd50;
   localparam logic [STEP_W-1:0] RST_STEP_SIZE  = 16'd5;
   localparam logic [PCT_W-1:0]  RST_ACCEL_PCT  = 7'd30;
   localparam logic [PCT_W-1:0]  RST_SLOW_PCT   = 7'd70;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SLOW_DIV,
      ST_ZONE_SEL,
      ST_ACCEL_DIV,
      ST_ACCEL_CHK,
      ST_RATIO_LD,
      ST_RATIO_DIV,
      ST_RATIO_END,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic req_ready;
      logic div_step;
      logic emit;
   } ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/core/accel_decel_step_pacer_core.sv =====
// step pacer top level: control registers, run state, ramp sequencer and
// bit-serial restoring divider; depends on adsp_pkg
//
//  channel  dir  handshake               payload
//  req      in   req_tvalid/req_tready   tdata start_position, tuser operation
//  rsp      out  rsp_tvalid/rsp_tready   tdata position, period_now;
//                                        tuser advanced, running, step_pulse;
//                                        tlast finished_pulse
//  csr      in   csr_valid/csr_ready     csr_index, csr_wdata
//
// start, stop, idle ticks and ticks that do not expire the period go from idle straight to emit
// an advance that recomputes the period runs the divider one quotient bit
// per cycle: one division by 100 and one ratio in the slowdown zone, two
// divisions by 100 and one ratio in the speedup zone
// reset is synchronous and loads register defaults
// a result waiting in the output register does not block accepting the next item, only its emit
`default_nettype none

module accel_decel_step_pacer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [adsp_pkg::REQ_DATA_W-1:0]     req_tdata,   // start_position
   input  logic [adsp_pkg::OP_W-1:0]           req_tuser,   // operation
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [adsp_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // position, period_now
   output logic [adsp_pkg::RSP_USER_W-1:0]     rsp_tuser,   // advanced, running, step_pulse
   output logic                                rsp_tlast,   // finished_pulse
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [adsp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [adsp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import adsp_pkg::*;

   // control registers
   logic [PER_W-1:0]  min_period_ff, max_period_ff;
   logic [POS_W-1:0]  end_position_ff;
   logic [STEP_W-1:0] step_size_ff;
   logic              cycle_mode_ff, notify_ff;
   logic [PCT_W-1:0]  accel_pct_ff, slow_pct_ff;

   // run state
   state_type         state_ff, state_in;
   logic              active_ff, active_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [PER_W-1:0]  tick_ff, tick_in;
   logic [PER_W-1:0]  period_ff, period_in;
   logic              adv_ff, adv_in;
   logic              fin_ff, fin_in;

   // ramp operands
   logic              decel_ff, decel_in;
   logic [POS_W-1:0]  num_ff, num_in;
   logic [DVS_W-1:0]  zone_ff, zone_in;

   // divider
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // output register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;
   logic                  rsp_last_ff;

   ctrl_type ctrl;

   logic                    req_fire, out_free;
   logic [PER_W-1:0]        tick_inc;
   logic                    tick_hit;
   logic [POS_W:0]          pos_sum;
   logic                    at_end, ramp_go;
   logic [POS_W+PCT_W-1:0]  slow_prod, accel_prod;
   logic [DVD_W-1:0]        ratio_prod;
   logic                    rising;
   logic [PER_W-1:0]        spread;
   logic                    s_le_p;
   logic [DVS_W-1:0]        dec_zone;
   logic [POS_W-1:0]        dec_num;
   logic [DVS_W:0]          trial, trial_diff;
   logic                    trial_ge;
   logic [DVS_W-1:0]        rem_next;
   logic                    div_last;
   logic [PER_W:0]          f_val;
   logic                    inexact;
   logic [PER_W+1:0]        dec_up, acc_up;
   logic [PER_W+2:0]        acc_down;
   logic [PER_W-1:0]        acc_up_sat, ramp_period;

   assign req_fire  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;

   assign tick_inc = tick_ff + 1'b1;
   assign tick_hit = tick_inc >= period_ff;
   assign pos_sum  = {1'b0, pos_ff} + {{(POS_W+1-STEP_W){1'b0}}, step_size_ff};
   assign at_end   = pos_sum >= {1'b0, end_position_ff};
   assign ramp_go  = req_fire && (req_tuser == OP_TICK) && active_ff && tick_hit && !at_end;

   assign slow_prod  = end_position_ff * slow_pct_ff;
   assign accel_prod = end_position_ff * accel_pct_ff;
   assign rising     = max_period_ff >= min_period_ff;
   assign spread     = rising ? (max_period_ff - min_period_ff)
                              : (min_period_ff - max_period_ff);
   assign ratio_prod = num_ff * spread;

   assign s_le_p   = {1'b0, pos_ff} >= quo_ff;
   assign dec_zone = {1'b0, end_position_ff} - quo_ff;
   assign dec_num  = pos_ff - quo_ff[POS_W-1:0];

   // one restoring step per cycle
   assign trial      = {rem_ff, dvd_ff[DVD_W-1]};
   assign trial_diff = trial - {1'b0, dvs_ff};
   assign trial_ge   = trial >= {1'b0, dvs_ff};
   assign rem_next   = trial_ge ? trial_diff[DVS_W-1:0] : trial[DVS_W-1:0];
   assign div_last   = cnt_ff == CNT_W'(DVD_W - 1);

   // period from the ratio quotient
   assign f_val    = (ovf_ff || (quo_ff > QUO_W'(PER_CAP))) ? PER_CAP : quo_ff[PER_W:0];
   assign inexact  = rem_ff != '0;
   assign dec_up   = {2'b0, min_period_ff} + {1'b0, f_val};
   assign acc_up   = {2'b0, max_period_ff} + {1'b0, f_val};
   assign acc_down = {3'b0, max_period_ff} - {2'b0, f_val}
                     - {{(PER_W+2){1'b0}}, inexact};
   assign acc_up_sat = (acc_up[PER_W+1:PER_W] != 2'b0) ? PER_ONES : acc_up[PER_W-1:0];

   always_comb begin
      if (decel_ff) begin
         if (!rising) begin
            ramp_period = min_period_ff;
         end else if (dec_up > {2'b0, max_period_ff}) begin
            ramp_period = max_period_ff;
         end else begin
            ramp_period = dec_up[PER_W-1:0];
         end
      end else if (rising) begin
         if (acc_down[PER_W+2] || (acc_down[PER_W+1:0] < {2'b0, min_period_ff})) begin
            ramp_period = min_period_ff;
         end else begin
            ramp_period = acc_down[PER_W-1:0];
         end
      end else if (acc_up_sat < min_period_ff) begin
         ramp_period = min_period_ff;
      end else begin
         ramp_period = acc_up_sat;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ramp_go) begin
               state_in = ST_SLOW_DIV;
            end else if (req_fire) begin
               state_in = ST_EMIT;
            end
         end
         ST_SLOW_DIV: begin
            if (div_last) state_in = ST_ZONE_SEL;
         end
         ST_ZONE_SEL: begin
            if (!s_le_p) begin
               state_in = ST_ACCEL_DIV;
            end else if (dec_zone == '0) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_RATIO_LD;
            end
         end
         ST_ACCEL_DIV: begin
            if (div_last) state_in = ST_ACCEL_CHK;
         end
         ST_ACCEL_CHK: begin
            state_in = (quo_ff == '0) ? ST_EMIT : ST_RATIO_LD;
         end
         ST_RATIO_LD:  state_in = ST_RATIO_DIV;
         ST_RATIO_DIV: begin
            if (div_last) state_in = ST_RATIO_END;
         end
         ST_RATIO_END: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // controller outputs
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE:      ctrl.req_ready = 1'b1;
         ST_SLOW_DIV,
         ST_ACCEL_DIV,
         ST_RATIO_DIV: ctrl.div_step = 1'b1;
         ST_EMIT:      ctrl.emit = out_free;
         default:      ctrl = '0;
      endcase
   end

   assign req_tready = ctrl.req_ready;

   // datapath
   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      tick_in   = tick_ff;
      period_in = period_ff;
      adv_in    = adv_ff;
      fin_in    = fin_ff;
      decel_in  = decel_ff;
      num_in    = num_ff;
      zone_in   = zone_ff;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      ovf_in    = ovf_ff;
      cnt_in    = cnt_ff;

      if (ctrl.div_step) begin
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         rem_in = rem_next;
         quo_in = {quo_ff[QUO_W-2:0], trial_ge};
         ovf_in = ovf_ff || quo_ff[QUO_W-1];
         cnt_in = cnt_ff + 1'b1;
      end

      if (req_fire) begin
         adv_in = 1'b0;
         fin_in = 1'b0;
         unique case (req_tuser)
            OP_START: begin
               active_in = 1'b1;
               pos_in    = req_tdata;
               tick_in   = '0;
               period_in = max_period_ff;
            end
            OP_STOP: begin
               fin_in    = active_ff;
               active_in = 1'b0;
            end
            OP_TICK: begin
               if (active_ff) begin
                  tick_in = tick_inc;
                  if (tick_hit) begin
                     tick_in = '0;
                     adv_in  = 1'b1;
                     if (!at_end) begin
                        pos_in = pos_sum[POS_W-1:0];
                        dvd_in = {{(DVD_W-POS_W-PCT_W){1'b0}}, slow_prod};
                        dvs_in = DVS_W'(PCT_SCALE);
                        rem_in = '0;
                        quo_in = '0;
                        ovf_in = 1'b0;
                        cnt_in = '0;
                     end else if (cycle_mode_ff) begin
                        pos_in = '0;
                     end else begin
                        active_in = 1'b0;
                        pos_in    = end_position_ff;
                        fin_in    = 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end

      case (state_ff)
         ST_ZONE_SEL: begin
            decel_in = s_le_p;
            if (s_le_p) begin
               zone_in = dec_zone;
               num_in  = dec_num;
               if (dec_zone == '0) period_in = min_period_ff;
            end else begin
               num_in = pos_ff;
               dvd_in = {{(DVD_W-POS_W-PCT_W){1'b0}}, accel_prod};
               dvs_in = DVS_W'(PCT_SCALE);
               rem_in = '0;
               quo_in = '0;
               ovf_in = 1'b0;
               cnt_in = '0;
            end
         end
         ST_ACCEL_CHK: begin
            zone_in = quo_ff;
            if (quo_ff == '0) period_in = min_period_ff;
         end
         ST_RATIO_LD: begin
            dvd_in = ratio_prod;
            dvs_in = zone_ff;
            rem_in = '0;
            quo_in = '0;
            ovf_in = 1'b0;
            cnt_in = '0;
         end
         ST_RATIO_END: period_in = ramp_period;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff   <= RST_MIN_PERIOD;
         max_period_ff   <= RST_MAX_PERIOD;
         end_position_ff <= '0;
         step_size_ff    <= RST_STEP_SIZE;
         cycle_mode_ff   <= 1'b0;
         accel_pct_ff    <= RST_ACCEL_PCT;
         slow_pct_ff     <= RST_SLOW_PCT;
         notify_ff       <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MIN_PERIOD:   min_period_ff   <= csr_wdata[PER_W-1:0];
            CSR_MAX_PERIOD:   max_period_ff   <= csr_wdata[PER_W-1:0];
            CSR_END_POSITION: end_position_ff <= csr_wdata[POS_W-1:0];
            CSR_STEP_SIZE:    step_size_ff    <= csr_wdata[STEP_W-1:0];
            CSR_CYCLE_MODE:   cycle_mode_ff   <= csr_wdata[0];
            CSR_ACCEL_PCT:    accel_pct_ff    <= csr_wdata[PCT_W-1:0];
            CSR_SLOW_PCT:     slow_pct_ff     <= csr_wdata[PCT_W-1:0];
            CSR_NOTIFY:       notify_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         active_ff <= 1'b0;
         pos_ff    <= '0;
         tick_ff   <= '0;
         period_ff <= RST_MAX_PERIOD;
         adv_ff    <= 1'b0;
         fin_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         pos_ff    <= pos_in;
         tick_ff   <= tick_in;
         period_ff <= period_in;
         adv_ff    <= adv_in;
         fin_ff    <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      decel_ff <= decel_in;
      num_ff   <= num_in;
      zone_ff  <= zone_in;
      dvd_ff   <= dvd_in;
      dvs_ff   <= dvs_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      ovf_ff   <= ovf_in;
      cnt_ff   <= cnt_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         rsp_data_ff <= {period_ff, pos_ff};
         rsp_user_ff <= {adv_ff && notify_ff, active_ff, adv_ff};
         rsp_last_ff <= fin_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_stop_ends_run: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_tuser == OP_STOP) |=> !active_ff)
      else $error("run still active after stop transaction");

   a_finish_not_running: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tuser[1])
      else $error("finished result reports a running state");

   a_step_needs_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[0])
      else $error("step pulse without advance");

   a_ramp_above_min: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RATIO_END |=> period_ff >= $past(min_period_ff))
      else $error("ramp period below minimum");

endmodule

`default_nettype wire

// ===== verif/pacer_checker.sv =====
`timescale 1ns / 100ps
// pacer_checker: watches the request, response and register-write channels of the step pacer,
// predicts each response from its own copy of the run state and compares it field by field
// depends on adsp_pkg
module pacer_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [adsp_pkg::REQ_DATA_W-1:0]   req_tdata,   // start_position
   input  logic [adsp_pkg::OP_W-1:0]         req_tuser,   // operation
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [adsp_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // position, period_now
   input  logic [adsp_pkg::RSP_USER_W-1:0]   rsp_tuser,   // advanced, running, step_pulse
   input  logic                              rsp_tlast,   // finished_pulse
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [adsp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [adsp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                fail_count,
   output int                                pending,
   output logic                              run_active,
   output int                                n_checked,
   output int                                n_advanced,
   output int                                n_finished
);
   import adsp_pkg::*;

   localparam int MAX_PRINTED = 40;

   typedef struct packed {
      logic             advanced;
      logic [POS_W-1:0] position;
      logic             running;
      logic             finished;
      logic             step_pulse;
      logic [PER_W-1:0] period;
   } pacer_outcome_type;

   pacer_outcome_type queued_outcomes[$];

   logic [PER_W-1:0]  cfg_min, cfg_max;
   logic [POS_W-1:0]  cfg_end;
   logic [STEP_W-1:0] cfg_step;
   logic              cfg_cycle, cfg_notify;
   logic [PCT_W-1:0]  cfg_accel, cfg_slow;

   logic              run_on;
   logic [POS_W-1:0]  cur_pos;
   logic [PER_W-1:0]  tick_cnt, cur_period;

   task load_defaults();
      cfg_min    = RST_MIN_PERIOD;
      cfg_max    = RST_MAX_PERIOD;
      cfg_end    = '0;
      cfg_step   = RST_STEP_SIZE;
      cfg_cycle  = 1'b0;
      cfg_accel  = RST_ACCEL_PCT;
      cfg_slow   = RST_SLOW_PCT;
      cfg_notify = 1'b0;
      run_on     = 1'b0;
      cur_pos    = '0;
      tick_cnt   = '0;
      cur_period = RST_MAX_PERIOD;
   endtask

   task apply_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_MIN_PERIOD:   cfg_min    = data[PER_W-1:0];
         CSR_MAX_PERIOD:   cfg_max    = data[PER_W-1:0];
         CSR_END_POSITION: cfg_end    = data[POS_W-1:0];
         CSR_STEP_SIZE:    cfg_step   = data[STEP_W-1:0];
         CSR_CYCLE_MODE:   cfg_cycle  = data[0];
         CSR_ACCEL_PCT:    cfg_accel  = data[PCT_W-1:0];
         CSR_SLOW_PCT:     cfg_slow   = data[PCT_W-1:0];
         CSR_NOTIFY:       cfg_notify = data[0];
         default: ;
      endcase
   endtask

   // period for the next advance at new position p, exact integer ramp
   function automatic logic [PER_W-1:0] ramp_period(input logic [POS_W-1:0] p);
      longint pl, mn, mx, el, d, s, z, num, f, r, cap_q, cap_hi, pct_accel, pct_slow;
      bit     exact;
      pl = p;
      mn = cfg_min;
      mx = cfg_max;
      el = cfg_end;
      pct_accel = cfg_accel;
      pct_slow = cfg_slow;
      cap_q = PER_CAP;
      cap_hi = PER_ONES;
      d = (mx >= mn) ? mx - mn : mn - mx;
      s = el * pct_slow / PCT_SCALE;
      if (pl >= s) begin
         z = el - s;
         if (z == 0) return cfg_min;
         num = (pl - s) * d;
         f = num / z;
         exact = (num % z) == 0;
         if (f > cap_q) f = cap_q;
         if (mx >= mn) r = mn + f;
         else r = mn - f - (exact ? 0 : 1);
         if (r > mx) r = mx;
         if (r < mn) r = mn;
      end else begin
         z = el * pct_accel / PCT_SCALE;
         if (z == 0) return cfg_min;
         num = pl * d;
         f = num / z;
         exact = (num % z) == 0;
         if (f > cap_q) f = cap_q;
         if (mx >= mn) r = mx - f - (exact ? 0 : 1);
         else r = mx + f;
         if (r > cap_hi) r = cap_hi;
         if (r < mn) r = mn;
      end
      return r[PER_W-1:0];
   endfunction

   function pacer_outcome_type pace_item(input logic [OP_W-1:0] op,
                                         input logic [POS_W-1:0] start_pos);
      pacer_outcome_type res;
      logic [POS_W:0] sum;
      res = '0;
      case (op)
         OP_START: begin
            run_on = 1'b1;
            cur_pos = start_pos;
            tick_cnt = '0;
            cur_period = cfg_max;
         end
         OP_STOP: begin
            res.finished = run_on;
            run_on = 1'b0;
         end
         OP_TICK: begin
            if (run_on) begin
               tick_cnt = tick_cnt + 1'b1;
               if (tick_cnt >= cur_period) begin
                  sum = {1'b0, cur_pos} + {{(POS_W+1-STEP_W){1'b0}}, cfg_step};
                  tick_cnt = '0;
                  res.advanced = 1'b1;
                  if (sum >= {1'b0, cfg_end}) begin
                     if (cfg_cycle) begin
                        cur_pos = '0;
                     end else begin
                        run_on = 1'b0;
                        cur_pos = cfg_end;
                        res.finished = 1'b1;
                     end
                  end else begin
                     cur_pos = sum[POS_W-1:0];
                     cur_period = ramp_period(cur_pos);
                  end
               end
            end
         end
         default: ;
      endcase
      res.position = cur_pos;
      res.running = run_on;
      res.step_pulse = res.advanced & cfg_notify;
      res.period = cur_period;
      return res;
   endfunction

   task report_failure(input string what);
      fail_count++;
      if (fail_count <= MAX_PRINTED)
         $display("result %0d: %s", n_checked, what);
   endtask

   task check_field(input string field, input longint got, input longint want);
      if (got != want)
         report_failure($sformatf("%s got 0x%0h, expected 0x%0h", field, got, want));
   endtask

   always @(posedge clock) begin : watch
      pacer_outcome_type want, seen;
      if (reset) begin
         load_defaults();
         queued_outcomes.delete();
         fail_count = 0;
         n_checked = 0;
         n_advanced = 0;
         n_finished = 0;
      end else begin
         if (csr_valid && csr_ready)
            apply_write(csr_index, csr_wdata);
         if (req_tvalid && req_tready) begin
            want = pace_item(req_tuser, req_tdata[POS_W-1:0]);
            if (want.advanced) n_advanced++;
            if (want.finished) n_finished++;
            queued_outcomes.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.advanced = rsp_tuser[0];
            seen.running = rsp_tuser[1];
            seen.step_pulse = rsp_tuser[2];
            seen.position = rsp_tdata[POS_W-1:0];
            seen.period = rsp_tdata[POS_W+PER_W-1:POS_W];
            seen.finished = rsp_tlast;
            if (queued_outcomes.size() == 0) begin
               report_failure("response transaction with nothing outstanding");
            end else begin
               want = queued_outcomes.pop_front();
               check_field("advanced", seen.advanced, want.advanced);
               check_field("position", seen.position, want.position);
               check_field("running", seen.running, want.running);
               check_field("finished_pulse", seen.finished, want.finished);
               check_field("step_pulse", seen.step_pulse, want.step_pulse);
               check_field("period_now", seen.period, want.period);
            end
            n_checked++;
         end
      end
      pending <= queued_outcomes.size();
      run_active <= run_on;
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// tb: clock, reset, register programming and request/response traffic for the step pacer core;
// depends on adsp_pkg, accel_decel_step_pacer_core and pacer_checker
module tb;
   import adsp_pkg::*;

   localparam logic [OP_W-1:0] OP_NONE = 2'd3;   // unassigned code
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int ITEM_TARGET  = 800;
   localparam int PHASE_ITEMS  = 60;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_PHASE   = 2;
   localparam int RX_ALWAYS    = 0;
   localparam int RX_RANDOM    = 1;
   localparam int RX_PATTERN   = 2;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]       req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int   fail_count, pending, n_checked, n_advanced, n_finished;
   logic run_active;

   int   cycle_count = 0;
   int   rsp_mode = RX_ALWAYS;
   bit   hold_request = 1'b0;
   int   hold_left = 0;
   int   rx_count = 0;
   int   burst_left = 0;
   int   max_gap = 0;
   int   useful = 0;
   int   sent = 0;
   int   settings = 0;
   logic [POS_W-1:0] run_end = '0;

   accel_decel_step_pacer_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   pacer_checker pacer_chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending), .run_active(run_active),
      .n_checked(n_checked), .n_advanced(n_advanced), .n_finished(n_finished)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  CYCLE_LIMIT, pending);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // response side back-pressure
   always @(negedge clock) begin : rsp_pacing
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rx_count++;
         case (rsp_mode)
            RX_ALWAYS: rsp_tready <= 1'b1;
            RX_RANDOM: rsp_tready <= ($urandom_range(0, 3) != 0);
            default:   rsp_tready <= ((rx_count % 7) >= 3);
         endcase
      end
   end

   task write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task program_regs(input logic [PER_W-1:0] mn, input logic [PER_W-1:0] mx,
                     input logic [POS_W-1:0] e, input logic [STEP_W-1:0] st,
                     input logic cy, input logic [PCT_W-1:0] ac,
                     input logic [PCT_W-1:0] sl, input logic nt);
      write_reg(CSR_MIN_PERIOD, CSR_DATA_W'(mn));
      write_reg(CSR_MAX_PERIOD, CSR_DATA_W'(mx));
      write_reg(CSR_END_POSITION, CSR_DATA_W'(e));
      write_reg(CSR_STEP_SIZE, CSR_DATA_W'(st));
      write_reg(CSR_CYCLE_MODE, CSR_DATA_W'(cy));
      write_reg(CSR_ACCEL_PCT, CSR_DATA_W'(ac));
      write_reg(CSR_SLOW_PCT, CSR_DATA_W'(sl));
      write_reg(CSR_NOTIFY, CSR_DATA_W'(nt));
      @(negedge clock);
      csr_valid <= 1'b0;
      run_end = e;
      settings++;
   endtask

   task offer(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos);
      int gap;
      if (burst_left == 0) begin
         gap = (max_gap == 0) ? 0 : $urandom_range(1, max_gap);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= pos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      if (op == OP_START || run_active) useful++;
   endtask

   task drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [PCT_W-1:0] pct_pick(input bit edges);
      int k;
      k = $urandom_range(0, 2);
      if (edges) return (k == 0) ? 7'd0 : ((k == 1) ? 7'd100 : 7'd127);
      if ($urandom_range(0, 9) == 0) return PCT_W'($urandom_range(101, 127));
      return PCT_W'($urandom_range(0, 100));
   endfunction

   task random_settings();
      logic [PER_W-1:0]  mn, mx;
      logic [POS_W-1:0]  e;
      logic [STEP_W-1:0] st;
      int                kind;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         mn = ($urandom_range(0, 1) != 0) ? PER_ONES : '0;
         mx = ($urandom_range(0, 1) != 0) ? PER_ONES : '0;
         e  = ($urandom_range(0, 1) != 0) ? {POS_W{1'b1}} : '0;
         st = ($urandom_range(0, 1) != 0) ? {STEP_W{1'b1}} : '0;
      end else if (kind == 1) begin
         mn = PER_W'($urandom_range(0, 6));
         mx = PER_W'($urandom_range(0, 10));
         e  = POS_W'($urandom());
         st = STEP_W'($urandom());
      end else begin
         mn = PER_W'($urandom_range(0, 6));
         mx = PER_W'($urandom_range(0, 10));
         st = STEP_W'($urandom_range(0, 400));
         e  = POS_W'($urandom_range(0, 8 * st + 16));
      end
      program_regs(mn, mx, e, st, 1'($urandom_range(0, 1)), pct_pick(kind == 0),
                   pct_pick(kind == 0), 1'($urandom_range(0, 1)));
   endtask

   task random_item();
      logic [OP_W-1:0]  op;
      logic [POS_W-1:0] pos;
      int               roll;
      roll = $urandom_range(0, 99);
      if (!run_active && roll < 85) op = OP_START;
      else if (roll < 3) op = OP_NONE;
      else if (roll < 9) op = OP_STOP;
      else if (roll < 15) op = OP_START;
      else op = OP_TICK;
      if ($urandom_range(0, 9) < 7) pos = POS_W'($urandom_range(0, run_end));
      else pos = POS_W'($urandom());
      offer(op, pos);
   endtask

   initial begin : stimulus
      int phase, phase_end;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // slow ramp, notify on: idle operations, restart while running, stop while running
      program_regs(16'd2, 16'd6, 24'd100, 16'd7, 1'b0, 7'd30, 7'd70, 1'b1);
      offer(OP_TICK, 24'd0);
      offer(OP_STOP, 24'd0);
      offer(OP_NONE, {POS_W{1'b1}});
      offer(OP_START, 24'd0);
      repeat (6) offer(OP_TICK, 24'd0);
      offer(OP_START, 24'd90);
      repeat (6) offer(OP_TICK, 24'd0);
      offer(OP_STOP, 24'd0);
      drain();

      // zero periods, empty accel zone, slow point past the end, wrap at the top of range
      program_regs(16'd0, 16'd0, {POS_W{1'b1}}, {STEP_W{1'b1}}, 1'b1, 7'd0, 7'd127, 1'b0);
      offer(OP_START, {{(POS_W-1){1'b1}}, 1'b0});
      repeat (3) offer(OP_TICK, 24'd0);
      drain();

      // min above max, run ends at the end position
      program_regs(PER_ONES, 16'd0, 24'd200000, {STEP_W{1'b1}}, 1'b0, 7'd100, 7'd100, 1'b1);
      offer(OP_START, 24'd150000);
      offer(OP_TICK, 24'd0);
      offer(OP_START, 24'd0);
      offer(OP_TICK, 24'd0);
      offer(OP_TICK, 24'd0);
      drain();

      phase = 0;
      while (useful < ITEM_TARGET) begin
         random_settings();
         max_gap = $urandom_range(0, 6);
         rsp_mode = $urandom_range(RX_ALWAYS, RX_PATTERN);
         if (phase == HOLD_PHASE) begin
            max_gap = 0;
            rsp_mode = RX_ALWAYS;
            hold_request = 1'b1;
         end
         phase_end = useful + PHASE_ITEMS;
         while (useful < phase_end) random_item();
         drain();
         phase++;
      end

      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d request transactions over %0d register settings", sent, settings);
      $display("checked %0d responses: %0d advances, %0d finished runs",
               n_checked, n_advanced, n_finished);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
